### sv/sg3d_pkg.sv
// ----------------------------------------------------------------------------
// sg3d_pkg
// Types, kernel tables and helpers of the separable 3D gradient filter.
// ----------------------------------------------------------------------------
package sg3d_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int MAX_TAPS    = 7;
	localparam int COEF_BITS   = 17;
	localparam int ACC_BITS    = 56;
	localparam int HIST_BITS   = 48;
	localparam int HIST_DEPTH  = 7;

	// register indexes
	localparam logic [1:0] REG_KERNEL_KIND   = 2'd0;
	localparam logic [1:0] REG_GRADIENT_AXIS = 2'd1;

	// axis codes
	localparam logic [1:0] AXIS_INLINE = 2'd0;
	localparam logic [1:0] AXIS_XLINE  = 2'd1;
	localparam logic [1:0] AXIS_DEPTH  = 2'd2;

	// kernel kinds
	localparam logic [1:0] KIND_KROON3 = 2'd0;
	localparam logic [1:0] KIND_FARID5 = 2'd1;
	localparam logic [1:0] KIND_FARID7 = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;

	typedef struct packed {
		sample_t    sample0;
		sample_t    sample1;
		sample_t    sample2;
		sample_t    sample3;
		sample_t    sample4;
		sample_t    sample5;
		sample_t    sample6;
		logic [2:0] row_index;
		logic       column_start;
		logic       column_end;
	} in_item_t;

	typedef struct packed {
		sample_t gradient;
		logic    last;
	} out_item_t;

	// Q0.16 kernels, tap 0 first
	localparam coef_t SMOOTH_TAPS [3][7] = '{
		'{17'sd11727, 17'sd42081, 17'sd11727, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
		'{17'sd2468, 17'sd16328, 17'sd27943, 17'sd16328, 17'sd2468, 17'sd0, 17'sd0},
		'{17'sd309, 17'sd4543, 17'sd16083, 17'sd23666, 17'sd16083, 17'sd4543,
			17'sd309}
	};
	localparam coef_t DERIV_TAPS [3][7] = '{
		'{-17'sd32768, 17'sd0, 17'sd32768, 17'sd0, 17'sd0, 17'sd0, 17'sd0},
		'{-17'sd7183, -17'sd18133, 17'sd0, 17'sd18133, 17'sd7183, 17'sd0, 17'sd0},
		'{-17'sd1226, -17'sd8217, -17'sd12654, 17'sd0, 17'sd12654, 17'sd8217,
			17'sd1226}
	};

	// kind three behaves as the seven-tap kernel
	function automatic logic [1:0] eff_kind(input logic [1:0] kind);
		eff_kind = (kind > KIND_FARID7) ? KIND_FARID7 : kind;
	endfunction

	function automatic logic [2:0] tap_count(input logic [1:0] kind);
		logic [1:0] k;
		k = eff_kind(kind);
		unique case (k)
			KIND_KROON3: tap_count = 3'd3;
			KIND_FARID5: tap_count = 3'd5;
			default:     tap_count = 3'd7;
		endcase
	endfunction

	function automatic coef_t ktap(input logic [1:0] kind, input logic deriv,
			input logic [2:0] idx);
		logic [1:0] k;
		k = eff_kind(kind);
		if (idx > 3'd6)
			ktap = '0;
		else if (deriv)
			ktap = DERIV_TAPS[k][idx];
		else
			ktap = SMOOTH_TAPS[k][idx];
	endfunction

endpackage

### sv/separable_3d_gradient_filter.sv
// ----------------------------------------------------------------------------
// separable_3d_gradient_filter
// Separable 3D derivative filter, one inline row of crossline samples per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item is one inline row of a depth plane. Accepted when
//            in_valid is high and in_stall low. Rows 0..size-1 make a plane.
//   out_*  : one gradient item per completed plane once size planes are held;
//            taken when out_valid is high and out_stall low.
//   cfg_*  : register writes (kernel_kind, gradient_axis), always ready;
//            write only while the filter is idle.
// Timing: seven shared multiply lanes serve the crossline sum and, at plane
//   end, the depth FIR; a merge adder and one sequencer step per stage.
//   A row that does not end a plane holds the input through the MUL, MRG,
//   ROW and ACC steps after acceptance. A plane-ending row holds it through
//   PLANE as well, and through FIR, FMRG and SUM when it yields a result,
//   which shows on out_valid the cycle after the last step.
//   Rows with row_index beyond the kernel size are taken while the filter stays idle.
// Reset: clears state, output, accumulator, plane history and plane count;
//   kernel_kind = 0, gradient_axis = depth.
// Stall: a finished result waits in the output register; the filter keeps
//   accepting rows and holds a new result in its last step until it is free.
// ----------------------------------------------------------------------------
module separable_3d_gradient_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sg3d_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output sg3d_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [1:0]          cfg_data
);
	import sg3d_pkg::*;

	localparam int P_W    = HIST_BITS + COEF_BITS;
	localparam int S_W    = P_W + 3;
	localparam int ROW_W  = SAMPLE_BITS + COEF_BITS + 3;
	localparam int W_W    = ROW_W + COEF_BITS;
	localparam int ACC_X  = ((W_W > ACC_BITS) ? W_W : ACC_BITS) + 1;
	localparam int Q_W    = S_W - 32;

	localparam logic signed [ACC_X-1:0] ACC_MAX =
		{{(ACC_X-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
	localparam logic signed [ACC_X-1:0] ACC_MIN = ~ACC_MAX;
	localparam logic signed [Q_W-1:0] OUT_MAX =
		{{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [Q_W-1:0] OUT_MIN = ~OUT_MAX;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL   = 9'b000000010,
		ST_MRG   = 9'b000000100,
		ST_ROW   = 9'b000001000,
		ST_ACC   = 9'b000010000,
		ST_PLANE = 9'b000100000,
		ST_FIR   = 9'b001000000,
		ST_FMRG  = 9'b010000000,
		ST_SUM   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [1:0] kind_q, axis_q;
	logic [2:0] size;
	logic       accept;

	sample_t    samp_q [MAX_TAPS];
	logic [2:0] row_q;
	logic       end_q;
	logic [2:0] planes_q;

	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [HIST_BITS-1:0] hist_q [HIST_DEPTH];
	logic signed [W_W-1:0]       weight_s1;
	logic signed [S_W-1:0]       sum_s1;

	logic signed [HIST_BITS-1:0] lane_in   [MAX_TAPS];
	coef_t                       lane_coef [MAX_TAPS];
	logic signed [P_W-1:0]       lane_p    [MAX_TAPS];
	logic signed [S_W-1:0]       lane_sum;

	logic out_valid_q;
	out_item_t out_q;
	logic out_free;

	assign size      = tap_count(kind_q);
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_KROON3;
			axis_q <= AXIS_DEPTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KERNEL_KIND:   kind_q <= cfg_data;
				REG_GRADIENT_AXIS: axis_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lane operands: row samples in MUL, plane history otherwise
	always_comb begin
		for (int i = 0; i < MAX_TAPS; i++) begin
			if (state_q == ST_MUL) begin
				lane_in[i]   = HIST_BITS'(samp_q[i]);
				lane_coef[i] = ktap(kind_q, axis_q == AXIS_XLINE, 3'(i));
			end else begin
				lane_in[i]   = (3'(i) < size) ? hist_q[3'(size - 3'd1 - 3'(i))] : '0;
				lane_coef[i] = ktap(kind_q, axis_q == AXIS_DEPTH, 3'(i));
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < MAX_TAPS; g++) begin : g_lane
			sg3d_lane #(
				.DATA_BITS(HIST_BITS),
				.COEF_W   (COEF_BITS)
			) u_lane (
				.clk    (clk),
				.data   (lane_in[g]),
				.coef   (lane_coef[g]),
				.prod_s1(lane_p[g])
			);
		end
	endgenerate

	// merge of the lane products
	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < MAX_TAPS; i++)
			lane_sum = lane_sum + S_W'(lane_p[i]);
	end

	// datapath registers
	logic signed [ROW_W-1:0] row_sum;
	logic signed [ACC_X-1:0] acc_ext;
	logic signed [ACC_X-1:0] acc_new;
	logic signed [ACC_BITS:0] acc_rnd;
	logic signed [S_W-1:0]   fir_rnd;
	logic signed [Q_W-1:0]   fir_q;
	sample_t                 grad;

	assign row_sum = sum_s1[ROW_W-1:0];
	assign acc_ext = ((row_q == 3'd0) ? ACC_X'(0) : ACC_X'(acc_q)) + ACC_X'(weight_s1);
	assign acc_new = (acc_ext > ACC_MAX) ? ACC_MAX :
		(acc_ext < ACC_MIN) ? ACC_MIN : acc_ext;
	assign acc_rnd = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(32768);
	assign fir_rnd = sum_s1 + S_W'(64'h8000_0000);
	assign fir_q   = fir_rnd[S_W-1:32];
	assign grad    = (fir_q > OUT_MAX) ? OUT_MAX[SAMPLE_BITS-1:0] :
		(fir_q < OUT_MIN) ? OUT_MIN[SAMPLE_BITS-1:0] : fir_q[SAMPLE_BITS-1:0];

	always_ff @(posedge clk) begin
		sum_s1    <= lane_sum;
		weight_s1 <= W_W'(row_sum) * W_W'(ktap(kind_q, axis_q == AXIS_INLINE, row_q));
		if (accept) begin
			samp_q[0] <= (in_data.sample0 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample0;
			samp_q[1] <= (in_data.sample1 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample1;
			samp_q[2] <= (in_data.sample2 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample2;
			samp_q[3] <= (in_data.sample3 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample3;
			samp_q[4] <= (in_data.sample4 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample4;
			samp_q[5] <= (in_data.sample5 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample5;
			samp_q[6] <= (in_data.sample6 == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) ? '0 : in_data.sample6;
			row_q     <= in_data.row_index;
			end_q     <= in_data.column_end;
		end
	end

	// sequencer, accumulator, history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			planes_q    <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < HIST_DEPTH; i++)
				hist_q[i] <= '0;
		end else begin
			// output valid: set by the final step, cleared when taken
			if ((state_q == ST_SUM) && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.column_start)
							planes_q <= '0;
						if (in_data.row_index < size)
							state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_MRG;
				ST_MRG: state_q <= ST_ROW;
				ST_ROW: state_q <= ST_ACC;
				ST_ACC: begin
					acc_q   <= acc_new[ACC_BITS-1:0];
					state_q <= (row_q == size - 3'd1) ? ST_PLANE : ST_IDLE;
				end
				ST_PLANE: begin
					for (int i = HIST_DEPTH - 1; i > 0; i--)
						hist_q[i] <= hist_q[i-1];
					hist_q[0] <= HIST_BITS'($signed(acc_rnd[ACC_BITS:16]));
					if (planes_q < size)
						planes_q <= planes_q + 3'd1;
					state_q <= ((planes_q < size) && (planes_q + 3'd1 < size)) ?
						ST_IDLE : ST_FIR;
				end
				ST_FIR:  state_q <= ST_FMRG;
				ST_FMRG: state_q <= ST_SUM;
				ST_SUM: begin
					if (out_free) begin
						out_q.gradient <= grad;
						out_q.last     <= end_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a new result only comes from the final step
	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_SUM))
		else $error("result appeared outside final step");

	// depth FIR runs only with a full set of planes
	a_fir_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIR |-> planes_q >= size)
		else $error("depth FIR started with too few planes");

	// rows outside the kernel leave the filter idle
	a_skip_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_data.row_index >= size) |=> state_q == ST_IDLE)
		else $error("out-of-range row was processed");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

endmodule

### sv/sg3d_lane.sv
// ----------------------------------------------------------------------------
// sg3d_lane
// One multiply lane: data times coefficient, product registered.
// ----------------------------------------------------------------------------
module sg3d_lane #(
	parameter int DATA_BITS = 48,
	parameter int COEF_W    = 17
) (
	input  logic                               clk,
	input  logic signed [DATA_BITS-1:0]        data,
	input  logic signed [COEF_W-1:0]           coef,
	output logic signed [DATA_BITS+COEF_W-1:0] prod_s1
);

	// registered product
	always_ff @(posedge clk) begin
		prod_s1 <= (DATA_BITS+COEF_W)'(data) * (DATA_BITS+COEF_W)'(coef);
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the separable 3D gradient filter: directed rows with
// hand-read results, then random columns checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;
	import sg3d_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = 40;

	typedef struct {
		in_item_t  item;
		logic      check;     // compare against typed value
		out_item_t want;
	} dir_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0] cfg_index;
	logic [1:0] cfg_data;

	// predictor state
	logic [1:0]        pr_kind;
	logic [1:0]        pr_axis;
	logic signed [55:0] pr_acc;
	logic signed [47:0] pr_hist [HIST_DEPTH];
	int                pr_seen;

	out_item_t grad_q [$];
	logic      hand_q [$];
	out_item_t hand_val_q [$];
	int        n_fail;
	int        idle_cnt;
	bit        long_hold;

	separable_3d_gradient_filter i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	// Q0.16 coefficient for the predictor
	function automatic longint tap_of(input int kind, input bit deriv, input int i);
		longint sm [3][7] = '{'{11727, 42081, 11727, 0, 0, 0, 0},
			'{2468, 16328, 27943, 16328, 2468, 0, 0},
			'{309, 4543, 16083, 23666, 16083, 4543, 309}};
		longint dv [3][7] = '{'{-32768, 0, 32768, 0, 0, 0, 0},
			'{-7183, -18133, 0, 18133, 7183, 0, 0},
			'{-1226, -8217, -12654, 0, 12654, 8217, 1226}};
		return deriv ? dv[kind][i] : sm[kind][i];
	endfunction

	function automatic longint clamp(input longint v, input int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	// add half then floor (arithmetic shift floors)
	function automatic longint round_q(input longint v, input int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sample_of(input sample_t s);
		if (s == {1'b1, {(SAMPLE_BITS-1){1'b0}}}) return 0;
		return longint'(s);
	endfunction

	// one row through the predictor; returns 1 when a gradient comes out
	function automatic bit filter_row(input in_item_t it, output out_item_t res);
		int      kind;
		int      size;
		int      row;
		longint  rowsum;
		longint  plane;
		longint  fir;
		sample_t s [7];
		s = '{it.sample0, it.sample1, it.sample2, it.sample3, it.sample4,
			it.sample5, it.sample6};
		kind = (pr_kind > KIND_FARID7) ? 2 : int'(pr_kind);
		size = 3 + 2 * kind;
		row = it.row_index;
		res = '0;
		if (it.column_start) pr_seen = 0;
		if (row >= size) return 0;
		rowsum = 0;
		for (int i = 0; i < size; i++)
			rowsum += sample_of(s[i]) * tap_of(kind, pr_axis == AXIS_XLINE, i);
		if (row == 0)
			pr_acc = ACC_BITS'(clamp(rowsum * tap_of(kind, pr_axis == AXIS_INLINE, row),
				ACC_BITS));
		else
			pr_acc = ACC_BITS'(clamp(longint'(pr_acc)
				+ rowsum * tap_of(kind, pr_axis == AXIS_INLINE, row), ACC_BITS));
		if (row != size - 1) return 0;
		plane = clamp(round_q(longint'(pr_acc), 16), HIST_BITS);
		for (int i = HIST_DEPTH - 1; i > 0; i--) pr_hist[i] = pr_hist[i-1];
		pr_hist[0] = HIST_BITS'(plane);
		if (pr_seen < size) pr_seen++;
		if (pr_seen < size) return 0;
		fir = 0;
		for (int i = 0; i < size; i++)
			fir += longint'(pr_hist[size-1-i]) * tap_of(kind, pr_axis == AXIS_DEPTH, i);
		res.gradient = sample_t'(clamp(round_q(fir, 32), SAMPLE_BITS));
		res.last = it.column_end;
		return 1;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};      // undefined
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			2: return {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};
			3, 4: return sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic in_item_t rand_row(input int row, input bit cs, input bit ce);
		in_item_t it;
		it.sample0 = rand_sample(); it.sample1 = rand_sample();
		it.sample2 = rand_sample(); it.sample3 = rand_sample();
		it.sample4 = rand_sample(); it.sample5 = rand_sample();
		it.sample6 = rand_sample();
		it.row_index = 3'(row);
		it.column_start = cs;
		it.column_end = ce;
		return it;
	endfunction

	// send one row, predict and queue the expectation
	task automatic send_row(input in_item_t it, input bit check, input out_item_t want);
		out_item_t res;
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (filter_row(it, res)) begin
			grad_q.push_back(res);
			hand_q.push_back(check);
			hand_val_q.push_back(want);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (grad_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_KERNEL_KIND) pr_kind = val;
		else pr_axis = val;
	endtask

	// whole column of planes with random content
	task automatic send_column(input int planes);
		int size;
		size = (pr_kind > KIND_FARID7) ? 7 : 3 + 2 * int'(pr_kind);
		for (int p = 0; p < planes; p++)
			for (int r = 0; r < size; r++)
				send_row(rand_row(r, p == 0 && r == 0, p == planes - 1), 1'b0, '0);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (grad_q.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected gradient %0d last %0d",
						out_data.gradient, out_data.last);
			end else begin
				out_item_t w;
				w = grad_q.pop_front();
				if (hand_q.pop_front()) begin
					out_item_t h;
					h = hand_val_q.pop_front();
					if (h != w) begin
						n_fail++;
						if (n_fail <= 10)
							$display("predictor disagrees with table: %0d vs %0d",
								w.gradient, h.gradient);
					end
				end else
					void'(hand_val_q.pop_front());
				if (out_data.gradient !== w.gradient || out_data.last !== w.last) begin
					n_fail++;
					if (n_fail <= 10)
						$display("gradient exp %0d/%0d got %0d/%0d", w.gradient, w.last,
							out_data.gradient, out_data.last);
				end
			end
		end
	end

	// receiver stall: random, sometimes zero, hold before each item, one long hold-off
	initial begin
		int wait_n;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				wait_n = 0;
			end else
				wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
			if (wait_n != 0) begin
				out_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	// watchdog on accepted and delivered items
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cnt <= 0;
		else begin
			idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCHDOG) begin
				$display("separable_3d_gradient_filter: mismatch");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t dir [$];
		out_item_t zero_last;
		in_item_t it;
		sample_t mx;
		sample_t mn;
		n_fail = 0;
		idle_cnt = 0;
		long_hold = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_KERNEL_KIND;
		cfg_data = 2'd0;
		pr_kind = KIND_KROON3;
		pr_axis = AXIS_DEPTH;
		pr_acc = '0;
		pr_seen = 0;
		for (int i = 0; i < HIST_DEPTH; i++) pr_hist[i] = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, reset kernel: three-tap, derivative in depth
		mx = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		mn = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		zero_last = '{gradient: '0, last: 1'b1};
		// undefined samples on three planes give a zero gradient
		for (int p = 0; p < 3; p++)
			for (int r = 0; r < 3; r++)
				dir.push_back('{'{mn, mn, mn, mn, mn, mn, mn, 3'(r), p == 0 && r == 0,
					p == 2}, p == 2 && r == 2, zero_last});
		// constant planes: depth derivative is zero
		for (int p = 0; p < 3; p++)
			for (int r = 0; r < 3; r++)
				dir.push_back('{'{mx, mx, mx, mx, mx, mx, mx, 3'(r), p == 0 && r == 0,
					p == 2}, p == 2 && r == 2, zero_last});
		// rows beyond the kernel size are ignored; the second one still restarts the column
		dir.push_back('{'{mx, mn, mx, mn, mx, mn, mx, 3'd3, 1'b0, 1'b0}, 1'b0, '0});
		dir.push_back('{'{mx, mn, mx, mn, mx, mn, mx, 3'd7, 1'b1, 1'b1}, 1'b0, '0});
		// extreme samples alternating from plane to plane, four planes with rows in reverse order
		for (int p = 0; p < 4; p++)
			for (int r = 2; r >= 0; r--)
				dir.push_back('{'{p[0] ? mx : mn + 24'sd1, mx, mn + 24'sd1, 24'sd1,
					-24'sd1, mx, mn, 3'(r), 1'b0, p == 3}, 1'b0, '0});
		foreach (dir[i]) send_row(dir[i].item, dir[i].check, dir[i].want);
		wait_idle();

		// random phases over settings, extremes and the odd codes included
		for (int ph = 0; ph < 16; ph++) begin
			write_reg(REG_KERNEL_KIND, 2'(ph % 4));
			write_reg(REG_GRADIENT_AXIS, 2'((ph / 4) % 4));
			if (ph == 5) long_hold = 1'b1;
			for (int c = 0; c < 3; c++) begin
				send_column($urandom_range(1, 5) + 2 * (ph % 2));
				// noise: stray, out-of-range or reordered rows
				if ($urandom_range(0, 3) == 0) begin
					it = rand_row($urandom_range(0, 7), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
					send_row(it, 1'b0, '0);
				end
			end
			// three rows written without a fresh start mark
			if (ph % 3 == 0)
				for (int r = 0; r < 3; r++)
					send_row(rand_row(r, 1'b0, 1'b1), 1'b0, '0);
			// sender pauses until every result has arrived
			wait_idle();
		end

		wait_idle();
		if (n_fail == 0)
			$display("separable_3d_gradient_filter: match");
		else
			$display("separable_3d_gradient_filter: mismatch");
		$finish;
	end

endmodule

### sim.f
sv/sg3d_pkg.sv
sv/sg3d_lane.sv
sv/separable_3d_gradient_filter.sv
tb/tb.sv
